// File: hdl/edge_directed_pixel_upscaler_2x_defines.svh
// Assertion macros shared by the upscaler modules.
`ifndef EDGE_DIRECTED_PIXEL_UPSCALER_2X_DEFINES_SVH
`define EDGE_DIRECTED_PIXEL_UPSCALER_2X_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset.
`define EDU2X_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// Condition that must never hold outside reset.
`define EDU2X_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define EDU2X_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define EDU2X_ASSERT_NEVER(lbl, ck, rn, cond, msg)
`endif

`endif

// File: hdl/edu2x_pkg.sv
// Shared types, constants and pixel functions of the 2x upscaler.
package edu2x_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int LINE_COUNT    = 3;
  localparam int MAX_HEIGHT    = 2048;
  localparam int ROW_W         = 11;
  localparam int COLQ_W        = 13;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = 2;
  localparam int QCNT_W        = 3;
  localparam int PEND_W        = 3;
  localparam int THRK_W        = 19;

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  typedef logic [1:0]  slot_t;
  typedef logic [31:0] pixel_t;

  // One queued input: its position, line slot and which positions it completes
  typedef struct packed {
    logic [COLQ_W-1:0] x;
    logic [ROW_W-1:0]  y;
    slot_t             slot;
    logic [2:0]        mask;
  } entry_t;

  function automatic slot_t slot_dec(input slot_t s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic slot_t slot_inc(input slot_t s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  // Weighted luma distance below threshold
  function automatic logic alike(input pixel_t p, input pixel_t q,
                                 input logic [THRK_W-1:0] thrk);
    logic signed [20:0] dr;
    logic signed [20:0] dg;
    logic signed [20:0] db;
    logic signed [20:0] s;
    logic [20:0] mag;
    dr  = 21'(signed'({1'b0, p[7:0]})) - 21'(signed'({1'b0, q[7:0]}));
    dg  = 21'(signed'({1'b0, p[15:8]})) - 21'(signed'({1'b0, q[15:8]}));
    db  = 21'(signed'({1'b0, p[23:16]})) - 21'(signed'({1'b0, q[23:16]}));
    s   = dr * 21'sd299 + dg * 21'sd587 + db * 21'sd114;
    mag = s[20] ? 21'(-s) : 21'(s);
    return mag < 21'(thrk);
  endfunction

  // Per-channel floor average
  function automatic pixel_t mix(input pixel_t a, input pixel_t b);
    pixel_t r;
    logic [8:0] sum;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      sum = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
      r[8*k +: 8] = sum[8:1];
    end
    return r;
  endfunction

endpackage

// File: hdl/edge_directed_pixel_upscaler_2x.sv
// Each position is read from the line store in phases (E and B, then D and F, then H) over
// the two read ports, then passes the neighbourhood register, corner stage and output register.
// The fetcher works on one position at a time and waits while the neighbourhood register is full;
// queued pixels wait meanwhile, and a pixel that completes nothing retires when it is taken.
// Each input gives zero to three positions; a new frame starts after earlier fetches drain.
// Reset (rst_n low, synchronous) clears counters and queues and loads register defaults.
module edge_directed_pixel_upscaler_2x #(
  parameter int MAX_WIDTH = edu2x_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // red, green, blue, alpha
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_col, out_row, out_red, out_green, out_blue, out_alpha
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);
  import edu2x_pkg::*;

  localparam int WB = $clog2(MAX_WIDTH+1);
  localparam int AW = $clog2(LINE_COUNT*MAX_WIDTH);

  logic [11:0]   width_r, height_r;
  logic [8:0]    thresh_r;
  logic          restart;
  logic [WB-1:0] weff;
  logic [11:0]   heff;
  logic          q_push, q_full, q_pop, q_empty, retire;
  entry_t        q_in, q_out;
  logic          ram_we, re_a, re_b;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]   wdata, rdata_a, rdata_b;

  // Configuration registers
  assign restart = cfg_we && ((cfg_addr == REG_WIDTH) || (cfg_addr == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd2048;
      height_r <= 12'd2048;
      thresh_r <= 9'd48;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        REG_THRESH: thresh_r <= cfg_wdata[8:0];
        default:    ;
      endcase
    end
  end

  // Clamp image size to the supported range
  always_comb begin
    if (width_r == '0) begin
      weff = WB'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      weff = WB'(MAX_WIDTH);
    end else begin
      weff = WB'(width_r);
    end
    if (height_r == '0) begin
      heff = 12'd1;
    end else if (32'(height_r) > MAX_HEIGHT) begin
      heff = 12'(MAX_HEIGHT);
    end else begin
      heff = height_r;
    end
  end

  edu2x_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .weff      (weff),
    .heff      (heff),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in),
    .retire    (retire),
    .ram_we    (ram_we),
    .ram_waddr (waddr),
    .ram_wdata (wdata)
  );

  edu2x_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  edu2x_ram #(.WIDTH(32), .DEPTH(LINE_COUNT*MAX_WIDTH)) u_line_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  edu2x_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .weff       (weff),
    .heff       (heff),
    .thresh     (thresh_r),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .retire     (retire),
    .re_a       (re_a),
    .raddr_a    (raddr_a),
    .rdata_a    (rdata_a),
    .re_b       (re_b),
    .raddr_b    (raddr_b),
    .rdata_b    (rdata_b),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hdl/edu2x_ram.sv
// Generic RAM: one write port, two registered read ports.
module edu2x_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 6144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read with registered data held between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hdl/edu2x_queue.sv
// Short command queue between the front and back parts.
`include "edge_directed_pixel_upscaler_2x_defines.svh"
module edu2x_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  edu2x_pkg::entry_t push_data,
  output logic              full,
  input  logic              pop,
  output edu2x_pkg::entry_t pop_data,
  output logic              empty
);
  import edu2x_pkg::*;

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slots[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  `EDU2X_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
  `EDU2X_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")

endmodule

// File: hdl/edu2x_front.sv
// Front part: accepts source pixels, writes the line store, queues work.
`include "edge_directed_pixel_upscaler_2x_defines.svh"
module edu2x_front #(
  parameter int MAX_WIDTH = edu2x_pkg::MAX_WIDTH_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                       weff,
  input  logic [11:0]                                          heff,
  input  logic                                                 in_tvalid,
  output logic                                                 in_tready,
  input  logic [31:0]                                          in_tdata,
  input  logic                                                 q_full,
  output logic                                                 q_push,
  output edu2x_pkg::entry_t                                    q_entry,
  input  logic                                                 retire,
  output logic                                                 ram_we,
  output logic [$clog2(edu2x_pkg::LINE_COUNT*MAX_WIDTH)-1:0]   ram_waddr,
  output logic [31:0]                                          ram_wdata
);
  import edu2x_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH+1);
  localparam int AW = $clog2(LINE_COUNT*MAX_WIDTH);
  localparam int CMPW = WB + PEND_W;

  logic [CW-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  slot_t             slot_r, slot_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              accept;
  logic              last_col;
  logic              last_row;
  logic              room;
  logic [AW-1:0]     base;

  assign last_col = (WB'(col_r) == weff - 1'b1);
  assign last_row = (12'(row_r) == heff - 12'd1);

  // Keep a line of distance to unread data; start a frame only when drained
  assign room = (CMPW'(pend_r) < CMPW'(weff)) &&
                (!((col_r == '0) && (row_r == '0)) || (pend_r == '0));
  assign in_tready = !q_full && room;
  assign accept    = in_tvalid && in_tready;

  // Queue one entry per accepted pixel
  assign q_push        = accept;
  assign q_entry.x     = COLQ_W'(col_r);
  assign q_entry.y     = row_r;
  assign q_entry.slot  = slot_r;
  assign q_entry.mask  = {last_row && last_col,
                          last_row && (col_r != '0),
                          row_r != '0};

  // Line store write
  always_comb begin
    case (slot_r)
      2'd0:    base = '0;
      2'd1:    base = AW'(MAX_WIDTH);
      default: base = AW'(2*MAX_WIDTH);
    endcase
  end
  assign ram_we    = accept;
  assign ram_waddr = base + AW'(col_r);
  assign ram_wdata = in_tdata;

  // Advance raster position and outstanding count
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    pend_nxt = pend_r + PEND_W'(accept) - PEND_W'(retire);
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      slot_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_r + 1'b1;
          slot_nxt = slot_inc(slot_r);
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      pend_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
      pend_r <= pend_nxt;
    end
  end

  `EDU2X_ASSERT_NEVER(a_pend_bound, clk, rst_n, pend_r > PEND_W'(QDEPTH + 1),
                      "outstanding count beyond queue and fetch")

endmodule

// File: hdl/edu2x_back.sv
// Back part: fetches neighbourhoods, blends corners, streams output pixels.
`include "edge_directed_pixel_upscaler_2x_defines.svh"
module edu2x_back #(
  parameter int MAX_WIDTH = edu2x_pkg::MAX_WIDTH_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                       weff,
  input  logic [11:0]                                          heff,
  input  logic [8:0]                                           thresh,
  input  logic                                                 q_empty,
  input  edu2x_pkg::entry_t                                    q_data,
  output logic                                                 q_pop,
  output logic                                                 retire,
  output logic                                                 re_a,
  output logic [$clog2(edu2x_pkg::LINE_COUNT*MAX_WIDTH)-1:0]   raddr_a,
  input  logic [31:0]                                          rdata_a,
  output logic                                                 re_b,
  output logic [$clog2(edu2x_pkg::LINE_COUNT*MAX_WIDTH)-1:0]   raddr_b,
  input  logic [31:0]                                          rdata_b,
  output logic                                                 out_tvalid,
  input  logic                                                 out_tready,
  output logic [55:0]                                          out_tdata,  // col, row, R, G, B, A
  output logic                                                 out_tlast
);
  import edu2x_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH+1);
  localparam int AW = $clog2(LINE_COUNT*MAX_WIDTH);
  localparam int OW = CW + 13;

  localparam logic [1:0] PH_EB   = 2'd0;
  localparam logic [1:0] PH_DF   = 2'd1;
  localparam logic [1:0] PH_H    = 2'd2;
  localparam logic [1:0] PH_HAND = 2'd3;

  localparam logic [1:0] POS_ABOVE = 2'd0;
  localparam logic [1:0] POS_LEFT  = 2'd1;
  localparam logic [1:0] POS_SELF  = 2'd2;

  function automatic logic [AW-1:0] addr_of(input slot_t s, input logic [CW-1:0] c);
    logic [AW-1:0] b;
    case (s)
      2'd0:    b = '0;
      2'd1:    b = AW'(MAX_WIDTH);
      default: b = AW'(2*MAX_WIDTH);
    endcase
    return b + AW'(c);
  endfunction

  // Fetch sequencer
  logic              cur_v_r;
  entry_t            cur_r;
  logic [1:0]        pos_r;
  logic [1:0]        phase_r;
  pixel_t            e_r, b_r, d_r, f_r;
  logic [2:0]        rest;
  logic              has_next;
  logic [1:0]        next_pos;
  logic [1:0]        first_pos;
  logic [CW-1:0]     px, x_cur, col_d, col_f;
  logic [ROW_W-1:0]  py;
  slot_t             ps, slot_b, slot_h;
  logic [AW-1:0]     a_e, a_b, a_d, a_f, a_h;

  // Compute and output stages
  logic              s1_v_r, s1_load, s1_free;
  pixel_t            s1_e_r, s1_b_r, s1_d_r, s1_f_r, s1_h_r;
  logic [CW-1:0]     s1_x_r;
  logic [ROW_W-1:0]  s1_y_r;
  logic              s1_last_r;
  logic              s2_v_r, s2_take, s2_load;
  pixel_t            s2_c_r [4];
  logic [CW-1:0]     s2_x_r;
  logic [ROW_W-1:0]  s2_y_r;
  logic              s2_last_r;
  logic [1:0]        cnt_r;
  logic              out_load;
  logic              out_v_r;
  logic [55:0]       out_data_r;
  logic              out_last_r;
  logic [THRK_W-1:0] thrk;
  logic              db, df, bh, bf, fh, dh;
  pixel_t            c0, c1, c2, c3;
  logic [OW-1:0]     col_ext;
  logic [11:0]       row_out;

  // Position order within an entry
  always_comb begin
    first_pos = q_data.mask[0] ? POS_ABOVE : (q_data.mask[1] ? POS_LEFT : POS_SELF);
    case (pos_r)
      POS_ABOVE: rest = {cur_r.mask[2], cur_r.mask[1], 1'b0};
      POS_LEFT:  rest = {cur_r.mask[2], 2'b00};
      default:   rest = 3'b000;
    endcase
    has_next = |rest;
    next_pos = rest[1] ? POS_LEFT : POS_SELF;
  end

  // Position and clamped neighbour addresses
  always_comb begin
    x_cur = CW'(cur_r.x);
    case (pos_r)
      POS_ABOVE: begin
        px = x_cur;
        py = cur_r.y - 1'b1;
        ps = slot_dec(cur_r.slot);
      end
      POS_LEFT: begin
        px = x_cur - 1'b1;
        py = cur_r.y;
        ps = cur_r.slot;
      end
      default: begin
        px = x_cur;
        py = cur_r.y;
        ps = cur_r.slot;
      end
    endcase
    slot_b = (py != '0) ? slot_dec(ps) : ps;
    slot_h = (12'(py) + 12'd1 < heff) ? slot_inc(ps) : ps;
    col_d  = (px != '0) ? px - 1'b1 : px;
    col_f  = (WB'(px) + 1'b1 < weff) ? px + 1'b1 : px;
    a_e    = addr_of(ps, px);
    a_b    = addr_of(slot_b, px);
    a_d    = addr_of(ps, col_d);
    a_f    = addr_of(ps, col_f);
    a_h    = addr_of(slot_h, px);
  end

  // Read issue: E and B, then D and F, then H
  always_comb begin
    re_a    = cur_v_r && (phase_r != PH_HAND);
    re_b    = cur_v_r && ((phase_r == PH_EB) || (phase_r == PH_DF));
    case (phase_r)
      PH_EB:   raddr_a = a_e;
      PH_DF:   raddr_a = a_d;
      default: raddr_a = a_h;
    endcase
    raddr_b = (phase_r == PH_EB) ? a_b : a_f;
  end

  assign s1_free = !s1_v_r || s2_take;
  assign s1_load = cur_v_r && (phase_r == PH_HAND) && s1_free;
  assign q_pop   = !cur_v_r && !q_empty;
  assign retire  = (q_pop && (q_data.mask == 3'b000)) || (s1_load && !has_next);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      phase_r <= PH_EB;
      pos_r   <= POS_ABOVE;
    end else if (!cur_v_r) begin
      if (q_pop && (q_data.mask != 3'b000)) begin
        cur_v_r <= 1'b1;
        pos_r   <= first_pos;
        phase_r <= PH_EB;
      end
    end else if (phase_r != PH_HAND) begin
      phase_r <= phase_r + 1'b1;
    end else if (s1_load) begin
      phase_r <= PH_EB;
      if (has_next) begin
        pos_r <= next_pos;
      end else begin
        cur_v_r <= 1'b0;
      end
    end
  end

  // Hold the entry and capture read data
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (cur_v_r && (phase_r == PH_DF)) begin
      e_r <= rdata_a;
      b_r <= rdata_b;
    end
    if (cur_v_r && (phase_r == PH_H)) begin
      d_r <= rdata_a;
      f_r <= rdata_b;
    end
  end

  // Neighbourhood register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= 1'b1;
    end else if (s2_load) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_e_r    <= e_r;
      s1_b_r    <= b_r;
      s1_d_r    <= d_r;
      s1_f_r    <= f_r;
      s1_h_r    <= rdata_a;
      s1_x_r    <= px;
      s1_y_r    <= py;
      s1_last_r <= !has_next;
    end
  end

  // Similarity tests and corner selection
  assign thrk = THRK_W'(thresh) * THRK_W'(1000);
  always_comb begin
    db = alike(s1_d_r, s1_b_r, thrk);
    df = alike(s1_d_r, s1_f_r, thrk);
    bh = alike(s1_b_r, s1_h_r, thrk);
    bf = alike(s1_b_r, s1_f_r, thrk);
    fh = alike(s1_f_r, s1_h_r, thrk);
    dh = alike(s1_d_r, s1_h_r, thrk);
    c0 = (db && !df && !bh) ? mix(s1_d_r, s1_b_r) : s1_e_r;
    c1 = (bf && !db && !fh) ? mix(s1_b_r, s1_f_r) : s1_e_r;
    c2 = (dh && !db && !fh) ? mix(s1_d_r, s1_h_r) : s1_e_r;
    c3 = (fh && !bf && !dh) ? mix(s1_f_r, s1_h_r) : s1_e_r;
  end

  // Corner serializer
  assign out_load = s2_v_r && (!out_v_r || out_tready);
  assign s2_take  = !s2_v_r || (out_load && (cnt_r == 2'd3));
  assign s2_load  = s1_v_r && s2_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (out_load) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (s2_load) begin
        s2_v_r <= 1'b1;
      end else if (out_load && (cnt_r == 2'd3)) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_c_r[0] <= c0;
      s2_c_r[1] <= c1;
      s2_c_r[2] <= c2;
      s2_c_r[3] <= c3;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Output register
  assign col_ext = OW'({s2_x_r, cnt_r[0]});
  assign row_out = {s2_y_r, cnt_r[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {s2_c_r[cnt_r], row_out, col_ext[11:0]};
      out_last_r <= s2_last_r && (cnt_r == 2'd3);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `EDU2X_ASSERT_IMPL(a_phase_needs_entry, clk, rst_n, phase_r != PH_EB, cur_v_r,
                     "fetch phase active without an entry")
  `EDU2X_ASSERT_IMPL(a_cnt_idle, clk, rst_n, !s2_v_r, cnt_r == 2'd0,
                     "corner counter moved without a position")
  `EDU2X_ASSERT_IMPL(a_retire_once, clk, rst_n, q_pop && (q_data.mask != 3'b000),
                     !retire, "entry retired on load")

endmodule

// File: bench/edge_directed_pixel_upscaler_2x_checker.sv
// Output checker for the 2x pixel upscaler: predicts corner pixels and compares.
`timescale 1ns / 100ps
module edge_directed_pixel_upscaler_2x_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count
);
  import edu2x_pkg::*;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [31:0] pix;
    logic        last;
  } corner_t;

  logic [31:0] lines [LINE_COUNT][MAX_WIDTH_DEF];
  int unsigned width_reg, height_reg, thresh_reg;
  int unsigned next_col, next_row;
  corner_t corner_q[$];

  assign pending_count = corner_q.size();

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    return (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
  endfunction

  function automatic logic [31:0] pix_at(int unsigned c, int unsigned r);
    return lines[r % LINE_COUNT][c % MAX_WIDTH_DEF];
  endfunction

  function automatic bit similar(logic [31:0] p, logic [31:0] q);
    int s;
    s = (int'(p[7:0]) - int'(q[7:0])) * 299 + (int'(p[15:8]) - int'(q[15:8])) * 587
      + (int'(p[23:16]) - int'(q[23:16])) * 114;
    if (s < 0) s = -s;
    return s < int'(thresh_reg * 1000);
  endfunction

  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    for (int k = 0; k < 4; k++) r[8*k +: 8] = 8'((9'(a[8*k +: 8]) + 9'(b[8*k +: 8])) >> 1);
    return r;
  endfunction

  task automatic push_corner(int unsigned c, int unsigned r, logic [31:0] p);
    corner_t t;
    t.col = 12'(c);
    t.row = 12'(r);
    t.pix = p;
    t.last = 1'b0;
    corner_q.push_back(t);
  endtask

  // Expand one source position into its four corners
  task automatic expand_position(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
    logic [31:0] e, b, d, f, hh;
    bit db, df, bh, bf, fh, dh;
    e = pix_at(x, y);
    b = pix_at(x, (y > 0) ? y - 1 : 0);
    d = pix_at((x > 0) ? x - 1 : 0, y);
    f = pix_at((x + 1 < w) ? x + 1 : w - 1, y);
    hh = pix_at(x, (y + 1 < h) ? y + 1 : h - 1);
    db = similar(d, b); df = similar(d, f); bh = similar(b, hh);
    bf = similar(b, f); fh = similar(f, hh); dh = similar(d, hh);
    push_corner(2 * x, 2 * y, (db && !df && !bh) ? blend(d, b) : e);
    push_corner(2 * x + 1, 2 * y, (bf && !db && !fh) ? blend(b, f) : e);
    push_corner(2 * x, 2 * y + 1, (dh && !db && !fh) ? blend(d, hh) : e);
    push_corner(2 * x + 1, 2 * y + 1, (fh && !bf && !dh) ? blend(f, hh) : e);
  endtask

  task automatic accept_pixel(logic [31:0] p);
    int unsigned w, h, x, y, before_n;
    w = eff_width();
    h = eff_height();
    x = next_col;
    y = next_row;
    before_n = corner_q.size();
    lines[y % LINE_COUNT][x % MAX_WIDTH_DEF] = p;
    if (y > 0) expand_position(x, y - 1, w, h);
    if (y == h - 1) begin
      if (x > 0) expand_position(x - 1, y, w, h);
      if (x == w - 1) expand_position(x, y, w, h);
    end
    if (corner_q.size() > before_n) corner_q[$].last = 1'b1;
    next_col = x + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = (y + 1 >= h) ? 0 : y + 1;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Track configuration, inputs and results at each rising edge
  always @(posedge clk) begin
    corner_t got, want;
    if (!rst_n) begin
      width_reg = 2048; height_reg = 2048; thresh_reg = 48;
      next_col = 0; next_row = 0;
      corner_q.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[11:0], out_tdata[23:12], out_tdata[55:24], out_tlast};
        if (corner_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          want = corner_q.pop_front();
          if (got.col != want.col)
            report_mismatch($sformatf("col got %0d want %0d", got.col, want.col));
          if (got.row != want.row)
            report_mismatch($sformatf("row got %0d want %0d", got.row, want.row));
          if (got.pix != want.pix)
            report_mismatch($sformatf("pixel at %0d,%0d got %h want %h",
                                      want.col, want.row, got.pix, want.pix));
          if (got.last != want.last)
            report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
        end
      end
      if (in_tvalid && in_tready) accept_pixel(in_tdata);
      if (cfg_we) begin
        case (cfg_addr)
          REG_WIDTH: begin
            width_reg = 32'(cfg_wdata); next_col = 0; next_row = 0;
          end
          REG_HEIGHT: begin
            height_reg = 32'(cfg_wdata); next_col = 0; next_row = 0;
          end
          REG_THRESH: thresh_reg = 32'(cfg_wdata[8:0]);
          default: ;
        endcase
      end
    end
  end
endmodule

// File: bench/edge_directed_pixel_upscaler_2x_test.sv
// Stimulus and verdict for the 2x pixel upscaler.
`timescale 1ns / 100ps
module edge_directed_pixel_upscaler_2x_test;
  import edu2x_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [11:0] cfg_wdata;
  int          fail_count;
  int          pending_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  edge_directed_pixel_upscaler_2x u_dut (.*);

  edge_directed_pixel_upscaler_2x_checker u_checker (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("edge_directed_pixel_upscaler_2x_test failed");
      $finish;
    end
  end

  // Random receiver stalls
  always @(negedge clk) begin
    out_tready <= !rst_n ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [11:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send one pixel; valid stays high across back-to-back transactions
  task automatic send_pixel(logic [31:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Pixel with a random palette so similar neighbors occur often
  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    case ($urandom_range(3))
      0: p = $urandom;
      1: p = {8'($urandom), {3{8'($urandom_range(1) ? 8'hff : 8'h00)}}};
      default: p = {8'($urandom), 8'($urandom_range(3) * 40), 8'($urandom_range(3) * 40),
                    8'($urandom_range(3) * 40)};
    endcase
    return p;
  endfunction

  task automatic run_frame(int w, int h, int thr, int n);
    drain();
    write_reg(REG_WIDTH, 12'(w));
    write_reg(REG_HEIGHT, 12'(h));
    write_reg(REG_THRESH, 12'(thr));
    for (int i = 0; i < n; i++) send_pixel(rand_pixel());
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_WIDTH;
    cfg_wdata = '0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extreme pixels, tiny and degenerate sizes, threshold extremes
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_HEIGHT, 12'd3);
    write_reg(REG_THRESH, 12'd256);
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'hff00_ff00);
    send_pixel(32'h00ff_00ff);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    run_frame(0, 0, 0, 3);
    run_frame(1, 4, 48, 4);
    run_frame(4, 1, 1, 4);
    run_frame(4095, 1, 256, 60);
    drain();
    write_reg(REG_UNUSED, 12'hfff);
    run_frame(2, 2, 511, 4);

    // Random phases of idling; narrow frames, partial frames and a mid-frame resize
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 46 : 38) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 46 : 38) : 0;
      run_frame($urandom_range(2, 8), $urandom_range(2, 6), $urandom_range(0, 256), 100);
      run_frame($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(20, 90), 10);
    end
    drain();
    if (fail_count == 0) begin
      $display("edge_directed_pixel_upscaler_2x_test passed");
    end else begin
      $display("edge_directed_pixel_upscaler_2x_test failed");
    end
    $finish;
  end
endmodule
